/* rtl/sfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg: shared constants for the smallest factor pair finder
// Widths of the ports, the internal number and divisor paths, the prime
// table geometry and the member count codes.
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam int unsigned N_BITS      = 32;     // significant bits of the input number
	localparam int unsigned PRIME_DEPTH = 8192;   // entries of the odd prime table

	localparam int unsigned NUM_W = 32;           // number port width
	localparam int unsigned LO_W  = 16;           // low_factor port width
	localparam int unsigned HI_W  = 32;           // high_factor port width
	localparam int unsigned MC_W  = 2;            // member_count port width

	// internal number width: the input port cuts wider settings
	localparam int unsigned N_W    = (N_BITS < NUM_W) ? N_BITS : NUM_W;
	// trial divisor width: holds one step past the square root of any number
	localparam int unsigned D_W    = N_W / 2 + 1;
	localparam int unsigned SQ_W   = 2 * D_W;
	localparam int unsigned TBL_W  = LO_W;
	localparam int unsigned P_MAX  = 2 ** TBL_W - 1;
	localparam int unsigned ADDR_W = $clog2(PRIME_DEPTH);
	localparam int unsigned CNT_W  = $clog2(PRIME_DEPTH + 1);
	// divider step counter width: counts down one step per quotient bit
	localparam int unsigned STEP_W = $clog2(N_W + 1);

	localparam logic [MC_W-1:0] CNT_EMPTY = 2'd0;
	localparam logic [MC_W-1:0] CNT_ONE   = 2'd1;
	localparam logic [MC_W-1:0] CNT_PAIR  = 2'd2;

endpackage

/* rtl/sfp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_ram: generic single-port RAM
// One write or read address per cycle, read data registered.
// ----------------------------------------------------------------------------
module sfp_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/sfp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_div: iterative restoring divider
// One quotient bit per cycle; quotient and remainder are valid with done.
// ----------------------------------------------------------------------------
module sfp_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [sfp_pkg::N_W-1:0]  dividend,
	input  logic [sfp_pkg::D_W-1:0]  divisor,
	output logic                     done,
	output logic [sfp_pkg::N_W-1:0]  quotient,
	output logic [sfp_pkg::D_W-1:0]  remainder
);
	import sfp_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [N_W-1:0]    quo_q;
	logic [D_W-1:0]    rem_q;
	logic [D_W-1:0]    dvs_q;

	logic [D_W:0] trial;
	logic [D_W:0] diff;
	logic         ge;

	// shift the next dividend bit into the partial remainder, subtract if it fits
	assign trial = {rem_q, quo_q[N_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(N_W);
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
				quo_q  <= {quo_q[N_W-2:0], ge};
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* rtl/smallest_factor_pair_finder_core.sv */
`timescale 1ns / 1ps
// 0, 1, 2, 3 and even numbers go from S_IDLE straight to S_FIN and on to the output
// register. Odd n >= 5: each trial divisor takes a table read or square, a compare
// and the 32-step shared divider; new candidates past the table add a primality
// check against stored primes. A prime near 2^32 is divided by every stored prime
// once the table is filled. No new word is taken until the last result is in the
// output register. Reset clears the sequencer, output register and table fill count.
// ----------------------------------------------------------------------------
// smallest_factor_pair_finder_core: trial division factorization
// Reports the factor set of an unsigned number as a count and two members.
// Odd divisors are tried while p*p <= n; odd primes found on the way are kept
// in a table that later words reuse.
// ----------------------------------------------------------------------------
module smallest_factor_pair_finder_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sfp_pkg::NUM_W-1:0]  number,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [sfp_pkg::MC_W-1:0]   member_count,
	output logic [sfp_pkg::LO_W-1:0]   low_factor,
	output logic [sfp_pkg::HI_W-1:0]   high_factor
);
	import sfp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,   // wait for a word
		S_T_CHK,  // more stored primes? issue table read
		S_T_RD,   // table data back: square it
		S_T_CMP,  // p*p > n ends the search, else divide n by p
		S_T_DIV,  // wait for n % p
		S_X_SQ,   // square the next odd candidate past the table
		S_X_CMP,  // d*d > n ends the search, else maybe grow the table
		S_P_CHK,  // primality check of d: issue table read
		S_P_RD,   // table data back: square it
		S_P_CMP,  // p*p > d proves d prime, else divide d by p
		S_P_DIV,  // wait for d % p
		S_X_DIV,  // wait for n % d
		S_FIN     // hand the result to the output register
	} state_t;

	state_t            state_q;
	logic [N_W-1:0]    n_q;        // number under work
	logic [CNT_W-1:0]  i_q;        // table index, search of n
	logic [CNT_W-1:0]  j_q;        // table index, primality check of d
	logic [D_W-1:0]    d_q;        // odd candidate past the table
	logic [D_W-1:0]    p_q;        // prime read from the table
	logic [SQ_W-1:0]   sq_q;       // registered square
	logic [CNT_W-1:0]  known_q;    // valid table entries
	logic [D_W-1:0]    last_q;     // largest candidate already classified

	logic [MC_W-1:0]   res_cnt_q;
	logic [D_W-1:0]    res_lo_q;
	logic [N_W-1:0]    res_hi_q;

	logic              out_valid_q;
	logic [MC_W-1:0]   out_cnt_q;
	logic [LO_W-1:0]   out_lo_q;
	logic [HI_W-1:0]   out_hi_q;

	logic              div_go_q;
	logic [N_W-1:0]    div_a_q;
	logic [D_W-1:0]    div_b_q;
	logic              div_done;
	logic [N_W-1:0]    div_quo;
	logic [D_W-1:0]    div_rem;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [TBL_W-1:0]  ram_wdata;
	logic [TBL_W-1:0]  ram_rdata;

	logic [D_W-1:0]    mul_op;
	logic [SQ_W-1:0]   sq_prod;
	logic [N_W-1:0]    n_in;
	logic [N_W-1:0]    n_half;
	logic              t_more;
	logic              p_more;
	logic              sq_gt_n;
	logic              sq_gt_d;
	logic              grow;
	logic              prime_new;
	logic              accept;

	assign accept  = in_valid && in_ready;
	assign n_in    = number[N_W-1:0];
	assign n_half  = {1'b0, n_in[N_W-1:1]};

	// one shared squarer: candidates in S_X_SQ, table data otherwise
	assign mul_op  = (state_q == S_X_SQ) ? d_q : D_W'(ram_rdata);
	assign sq_prod = {{D_W{1'b0}}, mul_op} * {{D_W{1'b0}}, mul_op};

	assign t_more  = i_q < known_q;
	assign p_more  = j_q < known_q;
	assign sq_gt_n = sq_q > SQ_W'(n_q);
	assign sq_gt_d = sq_q > SQ_W'(d_q);

	// extend the table only with the very next odd number that fits an entry, while there is room
	assign grow = (d_q == last_q + D_W'(2)) && (32'(d_q) <= 32'(P_MAX)) &&
		(known_q < CNT_W'(PRIME_DEPTH));

	// d proved prime: store it at the fill count this cycle
	assign prime_new = ((state_q == S_P_CHK) && !p_more) ||
		((state_q == S_P_CMP) && sq_gt_d);

	always_comb begin
		ram_we    = prime_new;
		ram_wdata = TBL_W'(d_q);
		if (prime_new) begin
			ram_addr = known_q[ADDR_W-1:0];
		end else if (state_q == S_P_CHK) begin
			ram_addr = j_q[ADDR_W-1:0];
		end else begin
			ram_addr = i_q[ADDR_W-1:0];
		end
	end

	sfp_ram #(
		.WIDTH (TBL_W),
		.DEPTH (PRIME_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	sfp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go_q),
		.dividend  (div_a_q),
		.divisor   (div_b_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			d_q         <= '0;
			p_q         <= '0;
			sq_q        <= '0;
			known_q     <= '0;
			last_q      <= D_W'(1);
			res_cnt_q   <= CNT_EMPTY;
			res_lo_q    <= '0;
			res_hi_q    <= '0;
			out_valid_q <= 1'b0;
			out_cnt_q   <= CNT_EMPTY;
			out_lo_q    <= '0;
			out_hi_q    <= '0;
			div_go_q    <= 1'b0;
			div_a_q     <= '0;
			div_b_q     <= '0;
		end else begin
			div_go_q <= 1'b0;
			// drop the output word once taken
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q <= n_in;
						i_q <= '0;
						if (n_in == '0) begin
							res_cnt_q <= CNT_EMPTY;
							res_lo_q  <= '0;
							res_hi_q  <= '0;
							state_q   <= S_FIN;
						end else if (n_in == N_W'(1)) begin
							res_cnt_q <= CNT_ONE;
							res_lo_q  <= D_W'(1);
							res_hi_q  <= N_W'(1);
							state_q   <= S_FIN;
						end else if (n_in < N_W'(4)) begin
							res_cnt_q <= CNT_PAIR;
							res_lo_q  <= D_W'(1);
							res_hi_q  <= n_in;
							state_q   <= S_FIN;
						end else if (!n_in[0]) begin
							// even: 2 and n/2, equal only for four
							res_cnt_q <= (n_half == N_W'(2)) ? CNT_ONE : CNT_PAIR;
							res_lo_q  <= D_W'(2);
							res_hi_q  <= n_half;
							state_q   <= S_FIN;
						end else begin
							state_q <= S_T_CHK;
						end
					end
				end

				S_T_CHK: begin
					if (t_more) begin
						state_q <= S_T_RD;
					end else begin
						// table exhausted: continue past the last classified candidate
						d_q     <= last_q + D_W'(2);
						state_q <= S_X_SQ;
					end
				end

				S_T_RD: begin
					p_q     <= D_W'(ram_rdata);
					sq_q    <= sq_prod;
					state_q <= S_T_CMP;
				end

				S_T_CMP: begin
					if (sq_gt_n) begin
						res_cnt_q <= CNT_PAIR;
						res_lo_q  <= D_W'(1);
						res_hi_q  <= n_q;
						state_q   <= S_FIN;
					end else begin
						div_a_q  <= n_q;
						div_b_q  <= p_q;
						div_go_q <= 1'b1;
						state_q  <= S_T_DIV;
					end
				end

				S_T_DIV: begin
					if (div_done) begin
						if (div_rem == '0) begin
							res_cnt_q <= (N_W'(p_q) == div_quo) ? CNT_ONE : CNT_PAIR;
							res_lo_q  <= p_q;
							res_hi_q  <= div_quo;
							state_q   <= S_FIN;
						end else begin
							i_q     <= i_q + CNT_W'(1);
							state_q <= S_T_CHK;
						end
					end
				end

				S_X_SQ: begin
					sq_q    <= sq_prod;
					state_q <= S_X_CMP;
				end

				S_X_CMP: begin
					if (sq_gt_n) begin
						res_cnt_q <= CNT_PAIR;
						res_lo_q  <= D_W'(1);
						res_hi_q  <= n_q;
						state_q   <= S_FIN;
					end else if (grow) begin
						j_q     <= '0;
						state_q <= S_P_CHK;
					end else begin
						div_a_q  <= n_q;
						div_b_q  <= d_q;
						div_go_q <= 1'b1;
						state_q  <= S_X_DIV;
					end
				end

				S_P_CHK: begin
					if (p_more) begin
						state_q <= S_P_RD;
					end else begin
						// no stored prime divides d: it was written this cycle
						known_q  <= known_q + CNT_W'(1);
						last_q   <= d_q;
						div_a_q  <= n_q;
						div_b_q  <= d_q;
						div_go_q <= 1'b1;
						state_q  <= S_X_DIV;
					end
				end

				S_P_RD: begin
					p_q     <= D_W'(ram_rdata);
					sq_q    <= sq_prod;
					state_q <= S_P_CMP;
				end

				S_P_CMP: begin
					if (sq_gt_d) begin
						known_q  <= known_q + CNT_W'(1);
						last_q   <= d_q;
						div_a_q  <= n_q;
						div_b_q  <= d_q;
						div_go_q <= 1'b1;
						state_q  <= S_X_DIV;
					end else begin
						div_a_q  <= N_W'(d_q);
						div_b_q  <= p_q;
						div_go_q <= 1'b1;
						state_q  <= S_P_DIV;
					end
				end

				S_P_DIV: begin
					if (div_done) begin
						if (div_rem == '0) begin
							// composite candidate: classify it, do not store
							last_q   <= d_q;
							div_a_q  <= n_q;
							div_b_q  <= d_q;
							div_go_q <= 1'b1;
							state_q  <= S_X_DIV;
						end else begin
							j_q     <= j_q + CNT_W'(1);
							state_q <= S_P_CHK;
						end
					end
				end

				S_X_DIV: begin
					if (div_done) begin
						if (div_rem == '0) begin
							res_cnt_q <= (N_W'(d_q) == div_quo) ? CNT_ONE : CNT_PAIR;
							res_lo_q  <= d_q;
							res_hi_q  <= div_quo;
							state_q   <= S_FIN;
						end else begin
							d_q     <= d_q + D_W'(2);
							state_q <= S_X_SQ;
						end
					end
				end

				S_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_cnt_q   <= res_cnt_q;
						out_lo_q    <= LO_W'(res_lo_q);
						out_hi_q    <= HI_W'(res_hi_q);
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign member_count = out_cnt_q;
	assign low_factor   = out_lo_q;
	assign high_factor  = out_hi_q;

endmodule

/* rtl/sfp_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_chk: port checker for the smallest factor pair finder
// Watches the handshakes and the shape of each reported factor set.
// ----------------------------------------------------------------------------
module sfp_chk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [sfp_pkg::NUM_W-1:0]  number,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [sfp_pkg::MC_W-1:0]   member_count,
	input  logic [sfp_pkg::LO_W-1:0]   low_factor,
	input  logic [sfp_pkg::HI_W-1:0]   high_factor
);
	import sfp_pkg::*;

	logic [HI_W-1:0] low_ext;
	logic            unused_ok;

	assign low_ext   = HI_W'(low_factor);
	assign unused_ok = ^number;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		out_valid && $stable(member_count) && $stable(low_factor) &&
		$stable(high_factor))
		else $error("output word changed while stalled");

	// ready is low in the cycle after each accepted word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && member_count == CNT_EMPTY |->
		low_factor == '0 && high_factor == '0)
		else $error("empty set with nonzero members");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && member_count == CNT_ONE |-> high_factor == low_ext)
		else $error("single member set with unequal members");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && member_count == CNT_PAIR |->
		low_factor != '0 && low_ext < high_factor && unused_ok == unused_ok)
		else $error("pair not ordered");

endmodule

bind smallest_factor_pair_finder_core sfp_chk u_sfp_chk (.*);

/* tb/tb_smallest_factor_pair_finder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smallest_factor_pair_finder_core: self-checking bench for the factor finder
// Sends numbers over the valid/ready input channel and predicts each factor set
// by plain trial division. A small scoreboard matches every returned word with
// the oldest prediction, field by field. Both channels idle in short random
// bursts, and the last stretch of the run runs with no idling.
// ----------------------------------------------------------------------------
module tb_smallest_factor_pair_finder_core;

	import sfp_pkg::*;

	// Run the clock for a bounded time: the first table build and the 20-bit
	// primes dominate the run.
	localparam int unsigned CYCLE_LIMIT  = 20_000_000;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned RANDOM_WORDS = 100;

	typedef struct packed {
		logic [MC_W-1:0] members;
		logic [LO_W-1:0] low;
		logic [HI_W-1:0] high;
	} factor_set_t;

	// Predict factor sets in input order and compare returned words with them.
	class factor_scoreboard;
		factor_set_t pending_sets[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Work out the factor set of an accepted number and queue it.
		function void note_number(logic [NUM_W-1:0] value);
			longint unsigned n;
			longint unsigned divisor;
			longint unsigned smallest;
			factor_set_t     fs;
			n        = value & ((64'd1 << N_W) - 64'd1);
			smallest = 0;
			if (n == 0) begin
				fs = '{CNT_EMPTY, '0, '0};
			end else if (n == 1) begin
				fs = '{CNT_ONE, LO_W'(1), HI_W'(1)};
			end else if (n < 4) begin
				fs = '{CNT_PAIR, LO_W'(1), HI_W'(n)};
			end else begin
				if (n[0] == 1'b0) begin
					smallest = 2;
				end else begin
					// Try odd divisors while d*d <= n; the first hit is prime.
					divisor = 3;
					while (smallest == 0 && divisor * divisor <= n) begin
						if (n % divisor == 0)
							smallest = divisor;
						divisor += 2;
					end
				end
				if (smallest == 0) begin
					fs = '{CNT_PAIR, LO_W'(1), HI_W'(n)};
				end else begin
					fs.low     = LO_W'(smallest);
					fs.high    = HI_W'(n / smallest);
					fs.members = (smallest == n / smallest) ? CNT_ONE : CNT_PAIR;
				end
			end
			pending_sets = {pending_sets, fs};
		endfunction

		// Match one returned word against the oldest prediction.
		function void check_result(logic [MC_W-1:0] members, logic [LO_W-1:0] low,
				logic [HI_W-1:0] high);
			factor_set_t want;
			if (pending_sets.size() == 0) begin
				$display("%0t: unexpected word count=%0d low=%0d high=%0d",
					$time, members, low, high);
				mismatches++;
				return;
			end
			want = pending_sets.pop_front();
			if (members !== want.members) begin
				$display("%0t: member_count expected %0d got %0d",
					$time, want.members, members);
				mismatches++;
			end
			if (low !== want.low) begin
				$display("%0t: low_factor expected %0d got %0d",
					$time, want.low, low);
				mismatches++;
			end
			if (high !== want.high) begin
				$display("%0t: high_factor expected %0d got %0d",
					$time, want.high, high);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [NUM_W-1:0]  number    = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [MC_W-1:0]   member_count;
	logic [LO_W-1:0]   low_factor;
	logic [HI_W-1:0]   high_factor;

	bit                idle_on    = 1'b1;
	int unsigned       stall_left = 0;
	int unsigned       cycles     = 0;

	factor_scoreboard  sb = new();

	smallest_factor_pair_finder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.number       (number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.member_count (member_count),
		.low_factor   (low_factor),
		.high_factor  (high_factor)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: now and then drop out_ready for a random stretch while idling is on.
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 3);
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Check every word that leaves the block, sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(member_count, low_factor, high_factor);
	end

	// Present one number, hold it until accepted, then note it for prediction.
	// Call and return at a falling edge so each edge carries one update.
	task automatic send_number(input logic [NUM_W-1:0] value);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		number   <= value;
		do @(posedge clk); while (!in_ready);
		sb.note_number(value);
		@(negedge clk);
	endtask

	// Hold the sender until every predicted word has come back; drop valid
	// first so the last word is not taken again once the block goes idle.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (sb.pending_sets.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Draw a number that keeps trial division short: big values only with a
	// small odd factor or an even bottom bit, odd values mostly below 2^16.
	function automatic logic [NUM_W-1:0] random_number();
		int unsigned kind;
		int unsigned factor;
		kind = $urandom_range(0, 99);
		if (kind < 20)
			return NUM_W'($urandom_range(0, 255));
		if (kind < 40)
			return $urandom & 32'hFFFF_FFFE;
		if (kind < 60) begin
			factor = 2 * $urandom_range(1, 49) + 1;
			return factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
		end
		if (kind < 85)
			return NUM_W'($urandom_range(0, 32'h0000_FFFF));
		return NUM_W'($urandom_range(0, 32'h000F_FFFF));
	endfunction

	// Corner words: empty, unit and small prime sets, prime squares (4 among
	// them), 16-bit and 20-bit primes, and all-ones style 32-bit values.
	logic [NUM_W-1:0] corner_numbers[] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd8, 32'd9,
		32'd15, 32'd25, 32'd49, 32'd121, 32'd65521, 32'd65535, 32'd65537,
		32'd1018081, 32'd1048573, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
		32'h8000_0000, 32'hFFFE_0001, 32'hAAAA_AAAA, 32'h5555_5555
	};

	initial begin
		// Reset once and release it at a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (corner_numbers[i])
			send_number(corner_numbers[i]);

		// Let the block empty out before random traffic starts.
		wait_for_drain();

		for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
			// Idle in two windows, run flat out in between and at the end.
			idle_on = (i < 30) || (i >= 45 && i < 70);
			if (i == 50)
				wait_for_drain();
			send_number(random_number());
		end
		in_valid <= 1'b0;

		// Wait for the last words, then give a stray word time to show up.
		while (sb.pending_sets.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending_sets.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
